>>> design/dcs_pkg.sv
`timescale 1ns / 1ps

package dcs_pkg;

  typedef enum logic [1:0] {
    CMD_START      = 2'd0,
    CMD_STOP       = 2'd1,
    CMD_SAMPLE_ONE = 2'd2,
    CMD_SAMPLE_TWO = 2'd3
  } cmd_e;

  // One unit of text work handed from the front to the back
  typedef struct packed {
    logic       pre_mark;   // "@" LF CR ahead of the sample line
    logic       sample;     // sample line present
    logic       chan_two;   // channel digit is '2', else '1'
    logic [3:0] d_hund;
    logic [3:0] d_tens;
    logic [3:0] d_ones;
    logic       post_mark;  // "#" LF CR at the end
  } job_t;

  typedef enum logic [3:0] {
    STEP_AT,
    STEP_AT_LF,
    STEP_AT_CR,
    STEP_CHAN,
    STEP_COLON,
    STEP_SPACE,
    STEP_HUND,
    STEP_TENS,
    STEP_ONES,
    STEP_LF,
    STEP_CR,
    STEP_HASH,
    STEP_HASH_LF,
    STEP_HASH_CR
  } step_e;

  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;

  localparam logic [7:0] RUN_LENGTH_RESET = 8'd10;

endpackage

>>> design/dcs_front.sv
`timescale 1ns / 1ps

module dcs_front #(
  parameter int ADC_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dcs_pkg::cmd_e        cmd_i,
  input  logic [ADC_BITS-1:0]  sample_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output dcs_pkg::job_t        job_o
);
  import dcs_pkg::*;

  logic       active_q, active_d;
  logic       exp_two_q, exp_two_d;
  logic [7:0] cnt_one_q, cnt_one_d;
  logic [7:0] cnt_two_q, cnt_two_d;
  logic [7:0] run_len_q;

  logic       accept;
  logic [7:0] top_val;
  logic [1:0] hund;
  logic [6:0] rem;
  logic [14:0] tens_prod;
  logic [3:0] tens;
  logic [7:0] tens_x10;
  logic [3:0] ones;
  logic [7:0] cnt_two_inc;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Decimal split of the kept byte; rem*205>>11 is rem/10 for rem below 100
  assign top_val   = sample_i[ADC_BITS-1 -: 8];
  assign hund      = (top_val >= 8'd200) ? 2'd2 : ((top_val >= 8'd100) ? 2'd1 : 2'd0);
  assign rem       = 7'(top_val - 8'(hund) * 8'd100);
  assign tens_prod = 15'(rem) * 15'd205;
  assign tens      = tens_prod[14:11];
  assign tens_x10  = 8'(tens) * 8'd10;
  assign ones      = 4'(8'(rem) - tens_x10);

  assign cnt_two_inc = cnt_two_q + 8'd1;

  always_comb begin
    active_d  = active_q;
    exp_two_d = exp_two_q;
    cnt_one_d = cnt_one_q;
    cnt_two_d = cnt_two_q;
    push_o    = 1'b0;
    job_o.pre_mark  = 1'b0;
    job_o.sample    = 1'b0;
    job_o.chan_two  = 1'b0;
    job_o.d_hund    = {2'b00, hund};
    job_o.d_tens    = tens;
    job_o.d_ones    = ones;
    job_o.post_mark = 1'b0;
    if (accept) begin
      case (cmd_i)
        CMD_START: begin
          active_d  = 1'b1;
          exp_two_d = 1'b0;
          cnt_one_d = '0;
          cnt_two_d = '0;
        end
        CMD_STOP: begin
          if (active_q) begin
            push_o          = 1'b1;
            job_o.post_mark = 1'b1;
            active_d        = 1'b0;
          end
        end
        CMD_SAMPLE_ONE: begin
          if (active_q && !exp_two_q && (cnt_one_q < run_len_q)) begin
            push_o         = 1'b1;
            job_o.pre_mark = (cnt_one_q == 8'd0);
            job_o.sample   = 1'b1;
            cnt_one_d      = cnt_one_q + 8'd1;
            exp_two_d      = 1'b1;
          end
        end
        CMD_SAMPLE_TWO: begin
          if (active_q && exp_two_q && (cnt_two_q < run_len_q)) begin
            push_o          = 1'b1;
            job_o.sample    = 1'b1;
            job_o.chan_two  = 1'b1;
            job_o.post_mark = (cnt_two_inc == run_len_q);
            cnt_two_d       = cnt_two_inc;
            exp_two_d       = 1'b0;
            if (cnt_two_inc == run_len_q) begin
              active_d = 1'b0;
            end
          end
        end
        default: begin
          active_d = active_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      exp_two_q <= 1'b0;
      cnt_one_q <= '0;
      cnt_two_q <= '0;
      run_len_q <= RUN_LENGTH_RESET;
    end else begin
      active_q  <= active_d;
      exp_two_q <= exp_two_d;
      cnt_one_q <= cnt_one_d;
      cnt_two_q <= cnt_two_d;
      if (cfg_we_i) begin
        run_len_q <= cfg_wdata_i;
      end
    end
  end

endmodule

>>> design/dcs_queue.sv
`timescale 1ns / 1ps

module dcs_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dcs_pkg::job_t push_job_i,
  input  logic          pop_i,
  output dcs_pkg::job_t head_o,
  output logic          full_o,
  output logic          empty_o
);
  import dcs_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  job_t            slots_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue read while empty");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill count out of step");

endmodule

>>> design/dcs_back.sv
`timescale 1ns / 1ps

module dcs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dcs_pkg::job_t head_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_char_o,
  output logic          out_last_o
);
  import dcs_pkg::*;

  logic       in_job_q;
  step_e      step_q;
  step_e      cur_step, nxt_step;
  logic       done;
  logic       load;
  logic [7:0] chr;
  logic       valid_q, last_q;
  logic [7:0] char_q;

  assign load = !empty_i && (!valid_q || out_ready_i);

  always_comb begin
    if (in_job_q) begin
      cur_step = step_q;
    end else if (head_i.pre_mark) begin
      cur_step = STEP_AT;
    end else if (head_i.sample) begin
      cur_step = STEP_CHAN;
    end else begin
      cur_step = STEP_HASH;
    end
  end

  // Next step; sections that the job lacks are skipped
  always_comb begin
    done     = 1'b0;
    nxt_step = cur_step;
    case (cur_step)
      STEP_AT_CR: begin
        if (head_i.sample) begin
          nxt_step = STEP_CHAN;
        end else if (head_i.post_mark) begin
          nxt_step = STEP_HASH;
        end else begin
          done = 1'b1;
        end
      end
      STEP_CR: begin
        if (head_i.post_mark) begin
          nxt_step = STEP_HASH;
        end else begin
          done = 1'b1;
        end
      end
      STEP_HASH_CR: begin
        done = 1'b1;
      end
      default: begin
        nxt_step = step_e'(cur_step + 4'd1);
      end
    endcase
  end

  always_comb begin
    case (cur_step)
      STEP_AT:      chr = CH_AT;
      STEP_AT_LF:   chr = CH_LF;
      STEP_AT_CR:   chr = CH_CR;
      STEP_CHAN:    chr = head_i.chan_two ? CH_TWO : CH_ONE;
      STEP_COLON:   chr = CH_COLON;
      STEP_SPACE:   chr = CH_SPACE;
      STEP_HUND:    chr = CH_ZERO + 8'(head_i.d_hund);
      STEP_TENS:    chr = CH_ZERO + 8'(head_i.d_tens);
      STEP_ONES:    chr = CH_ZERO + 8'(head_i.d_ones);
      STEP_LF:      chr = CH_LF;
      STEP_CR:      chr = CH_CR;
      STEP_HASH:    chr = CH_HASH;
      STEP_HASH_LF: chr = CH_LF;
      STEP_HASH_CR: chr = CH_CR;
      default:      chr = CH_CR;
    endcase
  end

  assign pop_o = load && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_job_q <= 1'b0;
      step_q   <= STEP_AT;
      valid_q  <= 1'b0;
    end else begin
      if (load) begin
        in_job_q <= !done;
        step_q   <= nxt_step;
        valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= chr;
      last_q <= done;
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |=> !$past(load)) else $error("output overwritten");
  a_pop_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (valid_q && last_q)) else $error("job retired without last flag");
  a_mid_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_job_q |-> !empty_i) else $error("job in progress with empty queue");

endmodule

>>> design/dual_channel_sample_ascii_sequencer.sv
`timescale 1ns / 1ps

// Start/stop/sample sequencer with a text output stream. Commands arrive on
// s_axis_tuser (start, stop, channel one sample, channel two sample) with the
// ADC word on s_axis_tdata; each command is taken while the queue is not
// full and turned into 0 to 11 ASCII characters, given out one per cycle
// on m_axis while m_axis_tready is high, with tlast on the final character
// of each command. A sample command costs 8 characters, plus 3 for the
// opening "@" line and 3 for the closing "#" line, so the sustained rate is
// set by the one-character-per-cycle output. A QUEUE_DEPTH job queue lets
// commands that produce no text, and short bursts, be taken while earlier text goes out.
module dual_channel_sample_ascii_sequencer #(
  parameter int ADC_BITS    = 12,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [7:0]                          cfg_wdata_i,   // run_length
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((ADC_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // [ADC_BITS-1:0] sample
  input  logic [1:0]                          s_axis_tuser,  // [1:0] command
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata,  // [7:0] char_out
  output logic                                m_axis_tlast
);
  import dcs_pkg::*;

  logic push, pop, q_full, q_empty;
  job_t push_job, head_job;

  dcs_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (cmd_e'(s_axis_tuser)),
    .sample_i    (s_axis_tdata[ADC_BITS-1:0]),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  dcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  dcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_job),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
